// ----- rtl/order_statistic_multiset_assert.svh -----
// Assertion macros for the checker of the order statistic multiset.
// No dependencies; included by the checker module.
`ifndef ORDER_STATISTIC_MULTISET_ASSERT_SVH
`define ORDER_STATISTIC_MULTISET_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define OSM_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication checked outside reset.
`define OSM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ----- rtl/osm_pkg.sv -----
// Package of the order statistic multiset: request and response types,
// opcodes, status codes and sequencer states. No dependencies.
package osm_pkg;

  localparam int unsigned TOTAL_W = 30;

  // Opcodes of a request.
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_RANK   = 3'd2;
  localparam logic [2:0] OP_KTH    = 3'd3;
  localparam logic [2:0] OP_PRED   = 3'd4;
  localparam logic [2:0] OP_SUCC   = 3'd5;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] operand_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    status_e            status;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_SRCH_CMP,
    S_FETCH,
    S_FETCH_CMP,
    S_INS_SHIFT,
    S_DEL_SHIFT,
    S_SCAN_RANK,
    S_SCAN_KTH,
    S_READ_RES
  } state_e;

endpackage

// ----- rtl/order_statistic_multiset.sv -----
// Order statistic multiset: sorted table of distinct values with counts.
// Depends on osm_pkg.
//
// Usage: a request (opcode, operand) is taken at a clock edge where start is
// high and busy is low. Exactly one response appears later on rsp_o for a
// single cycle, marked by done_o; the receiver cannot stall it. busy stays
// high from the cycle after a request that needs the table until the
// response cycle, where it already drops, so a new request may be given
// while a response is shown. Entries sit in one synchronous memory of value
// and count, kept in ascending order; a fill count marks which entries are
// live, so reset clears only control registers and needs no memory pass.
// Steps, with n live entries and pos the lower-bound index of the operand:
// the binary search takes a read state and a compare state per halving.
// Insert of a new value then moves n-pos entries, delete of a last copy
// n-pos-1 entries, one per cycle through the single read and write ports.
// Rank sums pos counts, one memory read per cycle. K-th smallest skips the
// search and scans from the bottom until the running sum reaches k.
// Predecessor and successor add a read of the neighbour entry, if any. Bad
// opcodes and a k out of range answer in the cycle after the request.
module order_statistic_multiset #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned COUNT_WIDTH = 20
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  osm_pkg::req_t req_i,
  output logic          done_o,
  output osm_pkg::rsp_t rsp_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned IW = AW + 1;
  localparam int unsigned EW = 32 + COUNT_WIDTH;
  localparam int unsigned TW = osm_pkg::TOTAL_W;
  localparam logic [IW-1:0] DEPTH_I = IW'(TABLE_DEPTH);

  osm_pkg::state_e state_q, state_d;
  logic [2:0]         op_q, op_d;
  logic signed [31:0] v_q, v_d;
  logic [IW-1:0]      lo_q, lo_d, hi_q, hi_d, i_q, i_d, used_q, used_d;
  logic [TW-1:0]      total_q, total_d, acc_q, acc_d;
  logic               pend_q;
  logic [AW-1:0]      rd_addr_q;
  logic               done_q, done_d;
  osm_pkg::rsp_t      rsp_q, rsp_d;

  // Memory ports.
  logic [EW-1:0] mem_q [TABLE_DEPTH];
  logic [EW-1:0] rdata_q, mem_wdata;
  logic [AW-1:0] mem_raddr, mem_waddr;
  logic          mem_re, mem_we;

  logic signed [31:0]     rd_val;
  logic [COUNT_WIDTH-1:0] rd_cnt;
  logic [IW:0]            mid_sum;
  logic [AW-1:0]          mid;
  logic                   found, kth_bad, kth_hit, accept;
  logic [IW-1:0]          nx;
  logic [32:0]            acc_sum;

  assign accept  = start && !busy;
  assign busy    = (state_q != osm_pkg::S_IDLE);
  assign done_o  = done_q;
  assign rsp_o   = rsp_q;

  // Fields of the entry that was read in the previous cycle.
  assign rd_val  = $signed(rdata_q[EW-1 -: 32]);
  assign rd_cnt  = rdata_q[COUNT_WIDTH-1:0];

  // Binary search midpoint and derived decisions.
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[AW:1];
  assign found   = pend_q && (rd_val == v_q);
  assign nx      = found ? (lo_q + IW'(1)) : lo_q;
  assign kth_bad = (req_i.operand_value <= 32'sd0) ||
                   ($unsigned(req_i.operand_value) > 32'(total_q));
  assign acc_sum = 33'(acc_q) + 33'(rd_cnt);
  assign kth_hit = pend_q && (acc_sum >= 33'($unsigned(v_q)));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      osm_pkg::S_IDLE: begin
        if (accept) begin
          if (req_i.opcode == osm_pkg::OP_KTH) begin
            state_d = kth_bad ? osm_pkg::S_IDLE : osm_pkg::S_SCAN_KTH;
          end else if (req_i.opcode <= osm_pkg::OP_SUCC) begin
            state_d = osm_pkg::S_SRCH;
          end
        end
      end
      osm_pkg::S_SRCH: begin
        state_d = (lo_q < hi_q) ? osm_pkg::S_SRCH_CMP : osm_pkg::S_FETCH;
      end
      osm_pkg::S_SRCH_CMP: state_d = osm_pkg::S_SRCH;
      osm_pkg::S_FETCH:    state_d = osm_pkg::S_FETCH_CMP;
      osm_pkg::S_FETCH_CMP: begin
        state_d = osm_pkg::S_IDLE;
        case (op_q)
          osm_pkg::OP_INSERT: begin
            if (!(&total_q) && !found && (used_q != DEPTH_I)) begin
              state_d = osm_pkg::S_INS_SHIFT;
            end
          end
          osm_pkg::OP_DELETE: begin
            if (found && (rd_cnt == COUNT_WIDTH'(1))) begin
              state_d = osm_pkg::S_DEL_SHIFT;
            end
          end
          osm_pkg::OP_RANK: state_d = osm_pkg::S_SCAN_RANK;
          osm_pkg::OP_PRED: begin
            if (lo_q != '0) state_d = osm_pkg::S_READ_RES;
          end
          osm_pkg::OP_SUCC: begin
            if (nx < used_q) state_d = osm_pkg::S_READ_RES;
          end
          default: state_d = osm_pkg::S_IDLE;
        endcase
      end
      osm_pkg::S_INS_SHIFT: begin
        if ((i_q == lo_q) && !pend_q) state_d = osm_pkg::S_IDLE;
      end
      osm_pkg::S_DEL_SHIFT: begin
        if ((i_q == used_q) && !pend_q) state_d = osm_pkg::S_IDLE;
      end
      osm_pkg::S_SCAN_RANK: begin
        if ((i_q == lo_q) && !pend_q) state_d = osm_pkg::S_IDLE;
      end
      osm_pkg::S_SCAN_KTH: begin
        if (kth_hit) state_d = osm_pkg::S_IDLE;
      end
      osm_pkg::S_READ_RES: state_d = osm_pkg::S_IDLE;
      default:             state_d = osm_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory control and response.
  always_comb begin
    op_d      = op_q;
    v_d       = v_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    i_d       = i_q;
    used_d    = used_q;
    total_d   = total_q;
    acc_d     = acc_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    mem_re    = 1'b0;
    mem_raddr = rd_addr_q;
    mem_we    = 1'b0;
    mem_waddr = rd_addr_q;
    mem_wdata = rdata_q;
    case (state_q)
      osm_pkg::S_IDLE: begin
        if (accept) begin
          op_d = req_i.opcode;
          v_d  = req_i.operand_value;
          lo_d = '0;
          hi_d = used_q;
          i_d  = '0;
          acc_d = '0;
          if (req_i.opcode > osm_pkg::OP_SUCC ||
              (req_i.opcode == osm_pkg::OP_KTH && kth_bad)) begin
            done_d = 1'b1;
            rsp_d.result_value = '0;
            rsp_d.status = osm_pkg::ST_NONE;
          end
        end
      end
      osm_pkg::S_SRCH: begin
        if (lo_q < hi_q) begin
          mem_re    = 1'b1;
          mem_raddr = mid;
        end
      end
      osm_pkg::S_SRCH_CMP: begin
        // The midpoint is still held in the read address register.
        if (rd_val < v_q) begin
          lo_d = IW'(rd_addr_q) + IW'(1);
        end else begin
          hi_d = IW'(rd_addr_q);
        end
      end
      osm_pkg::S_FETCH: begin
        if (lo_q < used_q) begin
          mem_re    = 1'b1;
          mem_raddr = lo_q[AW-1:0];
        end
      end
      osm_pkg::S_FETCH_CMP: begin
        rsp_d.result_value = '0;
        rsp_d.status = osm_pkg::ST_OK;
        done_d = 1'b1;
        case (op_q)
          osm_pkg::OP_INSERT: begin
            if (&total_q) begin
              rsp_d.status = osm_pkg::ST_FULL;
            end else if (found) begin
              if (&rd_cnt) begin
                rsp_d.status = osm_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = rd_addr_q;
                mem_wdata = {rdata_q[EW-1 -: 32], rd_cnt + COUNT_WIDTH'(1)};
                total_d   = total_q + TW'(1);
              end
            end else if (used_q == DEPTH_I) begin
              rsp_d.status = osm_pkg::ST_FULL;
            end else begin
              done_d = 1'b0;
              i_d    = used_q;
            end
          end
          osm_pkg::OP_DELETE: begin
            if (!found) begin
              rsp_d.status = osm_pkg::ST_NONE;
            end else if (rd_cnt != COUNT_WIDTH'(1)) begin
              mem_we    = 1'b1;
              mem_waddr = rd_addr_q;
              mem_wdata = {rdata_q[EW-1 -: 32], rd_cnt - COUNT_WIDTH'(1)};
              total_d   = total_q - TW'(1);
            end else begin
              done_d = 1'b0;
              i_d    = lo_q + IW'(1);
            end
          end
          osm_pkg::OP_RANK: begin
            done_d = 1'b0;
            i_d    = '0;
            acc_d  = '0;
          end
          osm_pkg::OP_PRED: begin
            if (lo_q == '0) begin
              rsp_d.status = osm_pkg::ST_NONE;
            end else begin
              done_d    = 1'b0;
              mem_re    = 1'b1;
              mem_raddr = AW'(lo_q - IW'(1));
            end
          end
          osm_pkg::OP_SUCC: begin
            if (nx >= used_q) begin
              rsp_d.status = osm_pkg::ST_NONE;
            end else begin
              done_d    = 1'b0;
              mem_re    = 1'b1;
              mem_raddr = nx[AW-1:0];
            end
          end
          default: rsp_d.status = osm_pkg::ST_NONE;
        endcase
      end
      osm_pkg::S_INS_SHIFT: begin
        // Move entries up one place, top first, then drop the new value in.
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = rd_addr_q + AW'(1);
          mem_wdata = rdata_q;
        end
        if (i_q > lo_q) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(i_q - IW'(1));
          i_d       = i_q - IW'(1);
        end else if (!pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = lo_q[AW-1:0];
          mem_wdata = {v_q, COUNT_WIDTH'(1)};
          used_d    = used_q + IW'(1);
          total_d   = total_q + TW'(1);
          done_d    = 1'b1;
          rsp_d.result_value = '0;
          rsp_d.status = osm_pkg::ST_OK;
        end
      end
      osm_pkg::S_DEL_SHIFT: begin
        // Move the entries above the removed one down one place.
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = rd_addr_q - AW'(1);
          mem_wdata = rdata_q;
        end
        if (i_q < used_q) begin
          mem_re    = 1'b1;
          mem_raddr = i_q[AW-1:0];
          i_d       = i_q + IW'(1);
        end else if (!pend_q) begin
          used_d  = used_q - IW'(1);
          total_d = total_q - TW'(1);
          done_d  = 1'b1;
          rsp_d.result_value = '0;
          rsp_d.status = osm_pkg::ST_OK;
        end
      end
      osm_pkg::S_SCAN_RANK: begin
        // Sum the counts of all entries below the lower bound.
        if (pend_q) acc_d = acc_sum[TW-1:0];
        if (i_q < lo_q) begin
          mem_re    = 1'b1;
          mem_raddr = i_q[AW-1:0];
          i_d       = i_q + IW'(1);
        end else if (!pend_q) begin
          done_d = 1'b1;
          rsp_d.result_value = $signed(32'(acc_q) + 32'd1);
          rsp_d.status = osm_pkg::ST_OK;
        end
      end
      osm_pkg::S_SCAN_KTH: begin
        // Running sum of counts from the bottom until it reaches k.
        if (pend_q) acc_d = acc_sum[TW-1:0];
        if (kth_hit) begin
          done_d = 1'b1;
          rsp_d.result_value = rd_val;
          rsp_d.status = osm_pkg::ST_OK;
        end else if (i_q < used_q) begin
          mem_re    = 1'b1;
          mem_raddr = i_q[AW-1:0];
          i_d       = i_q + IW'(1);
        end
      end
      osm_pkg::S_READ_RES: begin
        done_d = 1'b1;
        rsp_d.result_value = rd_val;
        rsp_d.status = osm_pkg::ST_OK;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= osm_pkg::S_IDLE;
      used_q  <= '0;
      total_q <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      total_q <= total_d;
      pend_q  <= mem_re;
      done_q  <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    v_q   <= v_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    i_q   <= i_d;
    acc_q <= acc_d;
    rsp_q <= rsp_d;
    if (mem_re) rd_addr_q <= mem_raddr;
  end

  // Entry memory, one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[mem_raddr];
  end

endmodule

// ----- rtl/osm_checker.sv -----
// Port-level checker of the order statistic multiset, bound to the top level.
// Depends on osm_pkg and order_statistic_multiset_assert.svh.
`include "order_statistic_multiset_assert.svh"

module osm_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          done_o,
  input osm_pkg::rsp_t rsp_o
);

  // A response closes the request, so the block is free again.
  `OSM_ASSERT_IMP(a_done_not_busy, clk_i, rst_ni, done_o, !busy)

  // A taken request either starts work or answers at once.
  `OSM_ASSERT_NEXT(a_req_progress, clk_i, rst_ni, start && !busy, busy || done_o)

  // Failed requests carry a zero result.
  `OSM_ASSERT_IMP(a_fail_zero, clk_i, rst_ni,
                  done_o && (rsp_o.status != osm_pkg::ST_OK), rsp_o.result_value == 32'sd0)

  // No response shows up in the first busy cycle of a request.
  `OSM_ASSERT_IMP(a_rise_no_done, clk_i, rst_ni, $rose(busy), !done_o)

endmodule

bind order_statistic_multiset osm_checker u_osm_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);
